FILE: rtl/core/golden_ratio_hsv_color_generator_macros.svh
// Assertion macros for the golden-ratio HSV colour generator.
`ifndef GOLDEN_RATIO_HSV_COLOR_GENERATOR_MACROS_SVH
`define GOLDEN_RATIO_HSV_COLOR_GENERATOR_MACROS_SVH

// Same-cycle implication, reset masked.
`define GHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define GHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ghc_pkg.sv
// Shared types, constants and helpers for the golden-ratio HSV colour generator.
package ghc_pkg;

  localparam logic [7:0] SAT_RESET = 8'd128;
  localparam logic [7:0] VAL_RESET = 8'd243;

  localparam logic REG_SAT = 1'b0;
  localparam logic REG_VAL = 1'b1;

  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 8;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FS,
    ST_Q,
    ST_GS,
    ST_T,
    ST_P,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FS,
    OP_Q,
    OP_GS,
    OP_T,
    OP_P
  } op_t;

  typedef struct packed {
    logic in_ready;
    op_t  op;
    logic cap_q;
    logic cap_t;
    logic load_out;
  } ctl_t;

  function automatic logic [7:0] chan_of(input logic [PROD_W-1:0] prod);
    logic [8:0] c;
    c = prod[PROD_W-1:24];
    return c[8] ? 8'hFF : c[7:0];
  endfunction

endpackage

FILE: rtl/core/golden_ratio_hsv_color_generator.sv
// Golden-ratio hue stepper with HSV to RGB conversion: top level.
// Each input beat (request bit set) advances the hue phase by the golden-ratio
// fraction of a turn, then converts the hue to 8-bit RGB with the configured
// saturation and value; with request clear the current hue is converted as is.
// The result is loaded from the done state after the product states FS, Q, GS,
// T and P; the next input beat is taken only once the sequencer is back in idle
// (later while a finished result still waits for the consumer): the five products P,
// Q, T, f*s and (1-f)*s go one per cycle through a single 25x8 multiplier under a
// small sequencer. in_tready is low while an item is in flight. Configuration
// writes are taken in any cycle and should only be issued while idle.
`include "golden_ratio_hsv_color_generator_macros.svh"

module golden_ratio_hsv_color_generator
  import ghc_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] request, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue, [39:24] hue_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [63:0] GOLD_Q32 = 64'd2654435769;
  localparam logic [PHASE_BITS-1:0] PHASE_STEP =
    PHASE_BITS'(((GOLD_Q32 << PHASE_BITS) + 64'h8000_0000) >> 32);

  ctl_t ctl;

  logic [7:0]            sat_r;
  logic [7:0]            val_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [PHASE_BITS+15:0] hue_ext;
  logic [15:0]           hue_nxt;
  logic [18:0]           h6;
  logic [15:0]           hue_r;
  logic [15:0]           frac_r;
  logic [2:0]            sector_r;
  logic [7:0]            q_r;
  logic [7:0]            t_r;
  logic [PROD_W-1:0]     prod;
  logic [7:0]            p_chan;
  logic [7:0]            red_nxt;
  logic [7:0]            green_nxt;
  logic [7:0]            blue_nxt;
  logic                  out_valid_r;
  logic [39:0]           out_data_r;
  logic                  in_accept;
  logic                  out_hold;

  assign in_accept = in_tvalid && ctl.in_ready;
  assign out_hold  = out_valid_r && !out_tready;
  assign in_tready = ctl.in_ready;
  assign cfg_ready = 1'b1;

  ghc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_hold (out_hold),
    .ctl      (ctl)
  );

  ghc_mul u_mul (
    .clk  (clk),
    .op   (ctl.op),
    .frac (frac_r),
    .sat  (sat_r),
    .val  (val_r),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= SAT_RESET;
      val_r <= VAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAT: sat_r <= cfg_data;
        REG_VAL: val_r <= cfg_data;
        default: sat_r <= sat_r;
      endcase
    end
  end

  assign phase_nxt = in_tdata[0] ? phase_r + PHASE_STEP : phase_r;
  assign hue_ext   = {phase_nxt, 16'h0000};
  assign hue_nxt   = hue_ext[PHASE_BITS+15 -: 16];
  assign h6        = {1'b0, hue_nxt, 2'b00} + {2'b00, hue_nxt, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hue_r    <= hue_nxt;
      frac_r   <= h6[15:0];
      sector_r <= h6[18:16];
    end
    if (ctl.cap_q) begin
      q_r <= chan_of(prod);
    end
    if (ctl.cap_t) begin
      t_r <= chan_of(prod);
    end
  end

  assign p_chan = chan_of(prod);

  always_comb begin
    case (sector_r)
      3'd0: begin
        red_nxt = val_r;  green_nxt = t_r;    blue_nxt = p_chan;
      end
      3'd1: begin
        red_nxt = q_r;    green_nxt = val_r;  blue_nxt = p_chan;
      end
      3'd2: begin
        red_nxt = p_chan; green_nxt = val_r;  blue_nxt = t_r;
      end
      3'd3: begin
        red_nxt = p_chan; green_nxt = q_r;    blue_nxt = val_r;
      end
      3'd4: begin
        red_nxt = t_r;    green_nxt = p_chan; blue_nxt = val_r;
      end
      default: begin
        red_nxt = val_r;  green_nxt = p_chan; blue_nxt = q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data_r <= {hue_r, blue_nxt, green_nxt, red_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `GHC_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready, "ready high after beat")
  `GHC_ASSERT_NEXT(a_result_held, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `GHC_ASSERT_NOW(a_load_only_free, ctl.load_out, !out_hold, "result overwritten")
  `GHC_ASSERT_NOW(a_rise_from_load, $rose(out_tvalid), $past(ctl.load_out), "spurious result")

endmodule

FILE: rtl/core/ghc_mul.sv
// Shared 25x8 multiplier with operand selection and registered product.
module ghc_mul
  import ghc_pkg::*;
(
  input  logic              clk,
  input  op_t               op,
  input  logic [15:0]       frac,
  input  logic [7:0]        sat,
  input  logic [7:0]        val,
  output logic [PROD_W-1:0] prod
);

  logic [MUL_A_W-1:0] a;
  logic [MUL_B_W-1:0] b;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;

  always_comb begin
    a = '0;
    b = '0;
    case (op)
      OP_FS: begin
        a = {9'd0, frac};
        b = sat;
      end
      OP_Q, OP_T: begin
        a = 25'h100_0000 - {1'b0, prod_r[23:0]};
        b = val;
      end
      OP_GS: begin
        a = {8'd0, 17'h1_0000 - {1'b0, frac}};
        b = sat;
      end
      OP_P: begin
        a = {9'h100 - {1'b0, sat}, 16'h0000};
        b = val;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign prod_nxt = {8'd0, a} * {25'd0, b};

  always_ff @(posedge clk) begin
    if (op != OP_NONE) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

FILE: rtl/core/ghc_ctrl.sv
// Sequencer issuing the five products of one colour through the shared multiplier.
module ghc_ctrl
  import ghc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_hold,
  output ctl_t ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_FS;
      ST_FS:   state_nxt = ST_Q;
      ST_Q:    state_nxt = ST_GS;
      ST_GS:   state_nxt = ST_T;
      ST_T:    state_nxt = ST_P;
      ST_P:    state_nxt = ST_DONE;
      ST_DONE: if (!out_hold) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '{in_ready: 1'b0, op: OP_NONE, cap_q: 1'b0, cap_t: 1'b0, load_out: 1'b0};
    case (state_r)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_FS:   ctl.op = OP_FS;
      ST_Q:    ctl.op = OP_Q;
      ST_GS: begin
        ctl.op    = OP_GS;
        ctl.cap_q = 1'b1;
      end
      ST_T:    ctl.op = OP_T;
      ST_P: begin
        ctl.op    = OP_P;
        ctl.cap_t = 1'b1;
      end
      ST_DONE: ctl.load_out = !out_hold;
      default: ctl.in_ready = 1'b0;
    endcase
  end

endmodule

FILE: test/tb_top.sv
// Self-checking bench for the golden-ratio HSV colour generator: stepping, conversion, registers.
module tb_top;
  import ghc_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam logic [15:0] HUE_STEP =
    16'(((64'h9E3779B9 << 16) + (64'd1 << 31)) >> 32);

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] hue;
  } color_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] request, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [7:0] red, [15:8] green, [23:16] blue, [39:24] hue_out
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  logic [15:0] hue_acc;
  logic [7:0]  sat_level;
  logic [7:0]  val_level;
  color_t      pending_colors[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned stall_cycles;
  int unsigned beats_sent;
  int unsigned colors_checked;
  int unsigned reg_writes;
  int unsigned mismatches;

  golden_ratio_hsv_color_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] clamp_byte(input longint unsigned x);
    return (x > 255) ? 8'hFF : x[7:0];
  endfunction

  // advance the hue when requested, then convert it by the six-sector rule
  function automatic color_t predict_color(input logic req);
    color_t            c;
    logic [18:0]       h6;
    logic [2:0]        sector;
    longint unsigned   f, s, v;
    logic [7:0]        cp, cq, ct, cv;
    if (req) begin
      hue_acc = hue_acc + HUE_STEP;
    end
    h6     = 19'(hue_acc) * 19'd6;
    sector = h6[18:16];
    f      = h6[15:0];
    s      = sat_level;
    v      = val_level;
    cv = clamp_byte(v);
    cp = clamp_byte((v * (256 - s)) >> 8);
    cq = clamp_byte((v * ((64'd1 << 24) - f * s)) >> 24);
    ct = clamp_byte((v * ((64'd1 << 24) - (65536 - f) * s)) >> 24);
    case (sector)
      3'd0: begin c.red = cv; c.green = ct; c.blue = cp; end
      3'd1: begin c.red = cq; c.green = cv; c.blue = cp; end
      3'd2: begin c.red = cp; c.green = cv; c.blue = ct; end
      3'd3: begin c.red = cp; c.green = cq; c.blue = cv; end
      3'd4: begin c.red = ct; c.green = cp; c.blue = cv; end
      default: begin c.red = cv; c.green = cp; c.blue = cq; end
    endcase
    c.hue = hue_acc;
    return c;
  endfunction

  task automatic send_beat(input logic req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, req};
    do @(posedge clk); while (!in_tready);
    pending_colors = {pending_colors, predict_color(req)};
    beats_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SAT) begin
      sat_level = data;
    end else begin
      val_level = data;
    end
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  // receiver: hold off while a stall is pending, else accept at random
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_colors.size() == 0) begin
        mismatches++;
        $display("%0t unexpected colour beat: actual 0x%0h", $time, out_tdata);
      end else begin
        want = pending_colors.pop_front();
        check_field("red",   want.red,   out_tdata[7:0]);
        check_field("green", want.green, out_tdata[15:8]);
        check_field("blue",  want.blue,  out_tdata[23:16]);
        check_field("hue",   want.hue,   out_tdata[39:24]);
        colors_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_defaults;
    send_beat(1'b0);
    repeat (6) send_beat(1'b1);
    send_beat(1'b0);
  endtask

  task automatic test_register_extremes;
    write_reg(REG_SAT, 8'd0);
    write_reg(REG_VAL, 8'd255);
    send_beat(1'b1);
    send_beat(1'b0);
    write_reg(REG_SAT, 8'd255);
    repeat (6) send_beat(1'b1);
    write_reg(REG_SAT, 8'd1);
    write_reg(REG_VAL, 8'd0);
    send_beat(1'b1);
    send_beat(1'b0);
    write_reg(REG_SAT, 8'd255);
    send_beat(1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (4) begin
      write_reg(REG_SAT, 8'($urandom_range(255)));
      write_reg(REG_VAL, 8'($urandom_range(255)));
      repeat (140) send_beat($urandom_range(99) < 75);
    end
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    hold_left = 300;
    repeat (40) send_beat(1'($urandom_range(1)));
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= 8'd0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_SAT;
    cfg_data      <= 8'd0;
    hue_acc        = 16'd0;
    sat_level      = SAT_RESET;
    val_level      = VAL_RESET;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_left      = 0;
    stall_cycles   = 0;
    beats_sent     = 0;
    colors_checked = 0;
    reg_writes     = 0;
    mismatches     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic(13, 58);
    test_random_traffic(58, 13);
    test_random_traffic(0, 0);
    test_backpressure();
    drain();

    $display("covered %0d request beats, %0d colours checked, %0d register writes",
             beats_sent, colors_checked, reg_writes);
    $display("saturation and value extremes, all sectors, sender/receiver stalls, long hold-off");
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ghc_pkg.sv
rtl/core/ghc_mul.sv
rtl/core/ghc_ctrl.sv
rtl/core/golden_ratio_hsv_color_generator.sv
test/tb_top.sv
